@@ hdl/y2r_pkg.sv @@
package y2r_pkg;

  localparam int COEF_FRAC_BITS = 8;
  localparam int COEF_W = 16;
  localparam int ROW_W = 48;
  localparam int OFS_W = 10;
  localparam int OFFS_REG_W = 30;
  localparam int CFG_IDX_W = 3;
  localparam int SUM_W = 30;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [CFG_IDX_W-1:0] REG_COEF_RED = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_GREEN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_BLUE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSETS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_ORDER = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_FORMAT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CHROMA_MODE = 3'd6;

  localparam logic [2:0] FMT_ARGB = 3'd0;
  localparam logic [2:0] FMT_BGRA = 3'd1;
  localparam logic [2:0] FMT_RGB24 = 3'd2;
  localparam logic [2:0] FMT_BGR24 = 3'd3;
  localparam logic [2:0] FMT_R210 = 3'd4;

  // front sequencer steps
  typedef enum logic [1:0] {
    STEP_IDLE,
    STEP_HELD,
    STEP_FIRST,
    STEP_SECOND
  } step_t;

  // one pixel job handed from the front to the back
  typedef struct packed {
    logic [7:0] luma;
    logic [7:0] u;
    logic [7:0] v;
    logic       run_last;
    logic       line_last;
  } pix_job_t;

endpackage

@@ hdl/y2r_front.sv @@
module y2r_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              source_order,
  input  logic              chroma_mode,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [31:0]       pixel_pair,
  input  logic              line_end,
  output logic              job_valid,
  input  logic              job_ready,
  output y2r_pkg::pix_job_t job
);

  // captured pair and the pixels still to issue from it
  logic [7:0] cur_y1, cur_y2, cur_u, cur_v;
  logic       cur_eol, cur_hold;
  y2r_pkg::step_t step, step_next;  // held pixel, first, second
  logic [7:0] held_luma, held_u, held_v;
  logic       pixel_pending, pending_next;
  logic       hold_now;

  logic [7:0] y1, y2, u, v;
  logic       last_step;

  always_comb begin
    if (!source_order) begin
      y1 = pixel_pair[31:24]; u = pixel_pair[23:16];
      y2 = pixel_pair[15:8];  v = pixel_pair[7:0];
    end else begin
      u = pixel_pair[31:24];  y1 = pixel_pair[23:16];
      v = pixel_pair[15:8];   y2 = pixel_pair[7:0];
    end
  end

  // job contents for the current step
  always_comb begin
    job = '0;
    last_step = 1'b0;
    case (step)
      y2r_pkg::STEP_HELD: begin
        job.luma = held_luma;
        job.u = 8'(({1'b0, held_u} + {1'b0, cur_u}) >> 1);
        job.v = 8'(({1'b0, held_v} + {1'b0, cur_v}) >> 1);
      end
      y2r_pkg::STEP_FIRST: begin
        job.luma = cur_y1; job.u = cur_u; job.v = cur_v;
        job.run_last = cur_hold;
        last_step = cur_hold;
      end
      y2r_pkg::STEP_SECOND: begin
        job.luma = cur_y2; job.u = cur_u; job.v = cur_v;
        job.run_last = 1'b1;
        job.line_last = cur_eol;
        last_step = 1'b1;
      end
      default: ;
    endcase
  end

  assign job_valid = (step != y2r_pkg::STEP_IDLE);
  assign in_ready = (step == y2r_pkg::STEP_IDLE) || (job_ready && last_step);
  assign hold_now = job_valid && job_ready && (step == y2r_pkg::STEP_FIRST) && cur_hold;

  // next step and pending flag
  always_comb begin
    step_next = step;
    pending_next = pixel_pending;
    if (job_valid && job_ready) begin
      case (step)
        y2r_pkg::STEP_HELD: step_next = y2r_pkg::STEP_FIRST;
        y2r_pkg::STEP_FIRST: step_next = cur_hold ? y2r_pkg::STEP_IDLE : y2r_pkg::STEP_SECOND;
        default: step_next = y2r_pkg::STEP_IDLE;
      endcase
      if (hold_now) pending_next = 1'b1;
    end
    if (in_valid && in_ready) begin
      step_next = pending_next ? y2r_pkg::STEP_HELD : y2r_pkg::STEP_FIRST;
      pending_next = 1'b0;
    end
  end

  // step sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= y2r_pkg::STEP_IDLE;
      pixel_pending <= 1'b0;
      held_luma <= '0; held_u <= '0; held_v <= '0;
    end else begin
      step <= step_next;
      pixel_pending <= pending_next;
      if (hold_now) begin
        held_luma <= cur_y2; held_u <= cur_u; held_v <= cur_v;
      end
      if (in_valid && in_ready) begin
        cur_y1 <= y1; cur_y2 <= y2; cur_u <= u; cur_v <= v;
        cur_eol <= line_end;
        cur_hold <= chroma_mode && !line_end;
      end
    end
  end

`ifndef SYNTHESIS
  a_ready_only_at_end: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> (step == y2r_pkg::STEP_IDLE || last_step)) else $error("ready mid pair");
  a_pending_step: assert property (@(posedge clk) disable iff (rst)
    (step == y2r_pkg::STEP_HELD) |-> !pixel_pending) else $error("pending set while averaging");
  a_eol_no_hold: assert property (@(posedge clk) disable iff (rst)
    (step != y2r_pkg::STEP_IDLE && cur_eol) |-> !cur_hold) else $error("hold at line end");
`endif

endmodule

@@ hdl/y2r_queue.sv @@
module y2r_queue #(
  parameter int DEPTH = y2r_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_valid,
  output logic              wr_ready,
  input  y2r_pkg::pix_job_t wr_data,
  output logic              rd_valid,
  input  logic              rd_ready,
  output y2r_pkg::pix_job_t rd_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  y2r_pkg::pix_job_t slots [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [AW:0]   count;
  logic          push, pop;

  assign wr_ready = (count != (AW+1)'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data = slots[rd_ptr];
  assign push = wr_valid && wr_ready;
  assign pop = rd_valid && rd_ready;

  // slot storage
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= wr_data;
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0; rd_ptr <= '0; count <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == AW'(DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      if (pop) rd_ptr <= (rd_ptr == AW'(DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= (AW+1)'(DEPTH)) else $error("queue overflow");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + 1'b1) else $error("count slip");
  a_empty_ptrs: assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> wr_ptr == rd_ptr) else $error("pointer mismatch");
`endif

endmodule

@@ hdl/y2r_back.sv @@
module y2r_back #(
  parameter int FRAC = y2r_pkg::COEF_FRAC_BITS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [47:0]       coef_row_red,
  input  logic [47:0]       coef_row_green,
  input  logic [47:0]       coef_row_blue,
  input  logic [29:0]       input_offsets,
  input  logic [2:0]        output_format,
  input  logic              job_valid,
  output logic              job_ready,
  input  y2r_pkg::pix_job_t job,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [31:0]       pixel_word,
  output logic [2:0]        byte_count,
  output logic              run_last,
  output logic              line_last
);

  localparam int SW = y2r_pkg::SUM_W;

  // stage 1: offset samples and products
  logic              s1_valid, s2_valid, s1_ready, s2_ready;
  logic signed [10:0] oy, ou, ov;
  logic signed [26:0] prod [9];
  logic              s1_rl, s1_ll, s2_rl, s2_ll;
  logic [7:0]        r8, g8, b8;
  logic [9:0]        r10, g10, b10;
  logic signed [SW-1:0] sum [3];
  logic [9:0]        chan [3];
  logic              ten;

  assign s2_ready = !out_valid || out_ready;
  assign s1_ready = !s2_valid || s2_ready;
  assign job_ready = !s1_valid || s1_ready;

  always_comb begin
    oy = 11'(signed'({3'b0, job.luma})) + 11'(signed'(input_offsets[9:0]));
    ou = 11'(signed'({3'b0, job.u})) + 11'(signed'(input_offsets[19:10]));
    ov = 11'(signed'({3'b0, job.v})) + 11'(signed'(input_offsets[29:20]));
  end

  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else if (job_ready) s1_valid <= job_valid;
    if (job_ready && job_valid) begin
      prod[0] <= signed'(coef_row_red[15:0]) * oy;
      prod[1] <= signed'(coef_row_red[31:16]) * ou;
      prod[2] <= signed'(coef_row_red[47:32]) * ov;
      prod[3] <= signed'(coef_row_green[15:0]) * oy;
      prod[4] <= signed'(coef_row_green[31:16]) * ou;
      prod[5] <= signed'(coef_row_green[47:32]) * ov;
      prod[6] <= signed'(coef_row_blue[15:0]) * oy;
      prod[7] <= signed'(coef_row_blue[31:16]) * ou;
      prod[8] <= signed'(coef_row_blue[47:32]) * ov;
      s1_rl <= job.run_last;
      s1_ll <= job.line_last;
    end
  end

  // stage 2: channel sums
  always_ff @(posedge clk) begin
    if (rst) s2_valid <= 1'b0;
    else if (s1_ready) s2_valid <= s1_valid;
    if (s1_ready && s1_valid) begin
      for (int c = 0; c < 3; c++)
        sum[c] <= SW'(prod[3*c]) + SW'(prod[3*c+1]) + SW'(prod[3*c+2]);
      s2_rl <= s1_rl;
      s2_ll <= s1_ll;
    end
  end

  // floor shift and clip
  assign ten = (output_format == y2r_pkg::FMT_R210);
  always_comb begin
    logic signed [SW-1:0] q;
    for (int c = 0; c < 3; c++) begin
      q = sum[c] >>> FRAC;
      if (q < 0) chan[c] = '0;
      else if (ten && q > 1023) chan[c] = 10'd1023;
      else if (!ten && q > 255) chan[c] = 10'd255;
      else chan[c] = q[9:0];
    end
    r10 = chan[0]; g10 = chan[1]; b10 = chan[2];
    r8 = chan[0][7:0]; g8 = chan[1][7:0]; b8 = chan[2][7:0];
  end

  // output register with packing
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (s2_ready) out_valid <= s2_valid;
    if (s2_ready && s2_valid) begin
      run_last <= s2_rl;
      line_last <= s2_ll;
      case (output_format)
        y2r_pkg::FMT_RGB24, y2r_pkg::FMT_BGR24: byte_count <= 3'd3;
        default: byte_count <= 3'd4;
      endcase
      case (output_format)
        y2r_pkg::FMT_BGRA: pixel_word <= {b8, g8, r8, 8'd0};
        y2r_pkg::FMT_RGB24: pixel_word <= {8'd0, r8, g8, b8};
        y2r_pkg::FMT_BGR24: pixel_word <= {8'd0, b8, g8, r8};
        y2r_pkg::FMT_R210: pixel_word <= {2'b0, r10, g10, b10};
        default: pixel_word <= {8'd0, r8, g8, b8};
      endcase
    end
  end

`ifndef SYNTHESIS
  a_hold_out: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid) else $error("result dropped");
  a_count_val: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (byte_count == 3'd3 || byte_count == 3'd4)) else $error("bad count");
  a_s2_stall: assert property (@(posedge clk) disable iff (rst)
    (s2_valid && !s2_ready) |=> s2_valid) else $error("stage lost");
`endif

endmodule

@@ hdl/yuv422_to_rgb_converter.sv @@
// yuv422 to rgb converter
// input stream: s_axis_tdata carries one 4:2:2 pixel pair (first stream byte in
// bits 31:24), s_axis_tlast marks the last pair of a line.
// output stream: m_axis_tdata carries one packed pixel word and its byte count,
// m_axis_tuser the run_last flag, m_axis_tlast the final pixel of a line.
// configuration: cfg_we/cfg_index/cfg_data write one register per cycle; they
// are written only while the block is idle: a user rule, not enforced here.
// throughput: one output pixel per cycle while neither side stalls, set by the
// front sequencer issuing one pixel per cycle. in averaging mode the first pair
// of a line issues one pixel and the last three (held pixel plus both).
// stages from pair accept to output: capture, queue, products, sums, output reg.
// reset clears config, step state, the held pixel and all queue and pipe valids.
// when the receiver stalls the output word holds, the pipe and the job queue
// fill, then the front stops taking pairs.
module yuv422_to_rgb_converter #(
  parameter int COEF_FRAC_BITS = y2r_pkg::COEF_FRAC_BITS,
  parameter int QUEUE_DEPTH = y2r_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // pixel_pair
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // pixel_word [31:0], byte_count [34:32]
  output logic        m_axis_tuser,   // run_last
  output logic        m_axis_tlast,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_data
);

  logic [47:0] coef_row_red, coef_row_green, coef_row_blue;
  logic [29:0] input_offsets;
  logic        source_order, chroma_mode;
  logic [2:0]  output_format;

  // register file
  always_ff @(posedge clk) begin
    if (rst) begin
      coef_row_red <= '0; coef_row_green <= '0; coef_row_blue <= '0;
      input_offsets <= '0; source_order <= 1'b0;
      output_format <= '0; chroma_mode <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        y2r_pkg::REG_COEF_RED: coef_row_red <= cfg_data;
        y2r_pkg::REG_COEF_GREEN: coef_row_green <= cfg_data;
        y2r_pkg::REG_COEF_BLUE: coef_row_blue <= cfg_data;
        y2r_pkg::REG_OFFSETS: input_offsets <= cfg_data[29:0];
        y2r_pkg::REG_SRC_ORDER: source_order <= cfg_data[0];
        y2r_pkg::REG_OUT_FORMAT: output_format <= cfg_data[2:0];
        y2r_pkg::REG_CHROMA_MODE: chroma_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  y2r_pkg::pix_job_t f_job, q_job;
  logic f_valid, f_ready, q_valid, q_ready;
  logic [31:0] pixel_word;
  logic [2:0]  byte_count;

  y2r_front u_front (
    .clk, .rst, .source_order, .chroma_mode,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .pixel_pair(s_axis_tdata), .line_end(s_axis_tlast),
    .job_valid(f_valid), .job_ready(f_ready), .job(f_job)
  );

  y2r_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk, .rst,
    .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_job),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_job)
  );

  y2r_back #(.FRAC(COEF_FRAC_BITS)) u_back (
    .clk, .rst, .coef_row_red, .coef_row_green, .coef_row_blue,
    .input_offsets, .output_format,
    .job_valid(q_valid), .job_ready(q_ready), .job(q_job),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .pixel_word, .byte_count,
    .run_last(m_axis_tuser), .line_last(m_axis_tlast)
  );

  assign m_axis_tdata = {5'd0, byte_count, pixel_word};

endmodule
